@@ hdl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and digit helpers for the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

    localparam int unsigned DIGIT_BITS = 6;
    localparam int unsigned CHAR_BITS  = 7;

    localparam logic [DIGIT_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 7'd48;
    localparam logic [CHAR_BITS-1:0]  ASCII_UPPER_A = 7'd65;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [CHAR_BITS-1:0]  char_t;

    // divider request from the sequencer
    typedef struct packed {
        logic start;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic   done;
        digit_t rem;
    } div_stat_t;

    // register values outside 2..36 are clamped
    function automatic digit_t clamp_base(input digit_t raw);
        digit_t base;
        if (raw < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = raw;
        end
        return base;
    endfunction

    function automatic char_t digit_to_ascii(input digit_t d);
        char_t c;
        if (d < DECIMAL_LIMIT) begin
            c = ASCII_ZERO + {1'b0, d};
        end else begin
            c = ASCII_UPPER_A + {1'b0, d - DECIMAL_LIMIT};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/radix_digit_converter_core.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a binary integer to base 2..36 and streams ASCII digits, MSD first.
// ----------------------------------------------------------------------------
// The bit-serial divider yields one quotient bit per cycle and one digit per
// division; divisions repeat until the quotient is zero or the buffer is full,
// then each digit goes through the READ, LOAD and OUT states, plus sink stalls.
// A zero input answers with one invalid word in the cycle after it is taken.
// One word in flight at a time: s_ready is high only while idle.
// Synchronous active-low reset; radix resets to 2, digit buffer is not cleared.
`default_nettype none

module radix_digit_converter_core #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [5:0]            cfg_radix,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_number_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [6:0]            m_digit_char,
    output logic                       m_last_digit,
    output logic                       m_invalid_input
);

    import rdc_pkg::*;

    localparam int unsigned IDX_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    digit_t              radix_reg;
    logic [IDX_BITS-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_BITS-1:0] rd_idx_reg, rd_idx_next;
    logic                m_valid_reg, m_valid_next;
    char_t               m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;
    logic                m_inv_reg, m_inv_next;

    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    digit_t                base;
    digit_t                ram_rd_data;

    logic in_fire;
    logic div_more;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign base      = clamp_base(radix_reg);

    // keep dividing while the quotient is nonzero and the buffer has room
    assign div_more = (div_quotient != '0) && (wr_idx_reg != IDX_BITS'(VALUE_BITS - 1));

    assign div_dividend  = (state_reg == ST_IDLE) ? s_number_in : div_quotient;
    assign div_req.start = (in_fire && (s_number_in != '0))
                        || ((state_reg == ST_DIV) && div_stat.done && div_more);

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .base     (base),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    rdc_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .aclk    (aclk),
        .wr_en   ((state_reg == ST_DIV) && div_stat.done),
        .wr_addr (wr_idx_reg),
        .wr_data (div_stat.rem),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_inv_next   = m_inv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    wr_idx_next = '0;
                    if (s_number_in == '0) begin
                        m_valid_next = 1'b1;
                        m_char_next  = '0;
                        m_last_next  = 1'b1;
                        m_inv_next   = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (div_more) begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end else begin
                        rd_idx_next = wr_idx_reg;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                m_valid_next = 1'b1;
                m_char_next  = digit_to_ascii(ram_rd_data);
                m_last_next  = (rd_idx_reg == '0);
                m_inv_next   = 1'b0;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_MIN;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_radix;
            end
        end
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_inv_reg  <= m_inv_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_digit_char    = m_char_reg;
    assign m_last_digit    = m_last_reg;
    assign m_invalid_input = m_inv_reg;

endmodule

`default_nettype wire

@@ hdl/rdc_ram.sv @@
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 31
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring bit-serial divider: one quotient bit per cycle by a 6-bit base.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_divider #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire rdc_pkg::div_req_t        req,
    input  wire logic [VALUE_BITS-1:0]    dividend,
    input  wire rdc_pkg::digit_t          base,
    output rdc_pkg::div_stat_t            stat,
    output logic      [VALUE_BITS-1:0]    quotient
);

    import rdc_pkg::*;

    localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    digit_t                rem_reg, rem_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIGIT_BITS:0]   trial;
    logic [DIGIT_BITS:0]   trial_diff;
    logic                  trial_ge;

    // shift the next dividend bit into the partial remainder
    assign trial      = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign trial_diff = trial - {1'b0, base};
    assign trial_ge   = (trial >= {1'b0, base});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(VALUE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], trial_ge};
            rem_next = trial_ge ? trial_diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ hdl/rdc_checker.sv @@
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker #(
    parameter int unsigned VALUE_BITS = 31
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [VALUE_BITS-1:0] s_number_in,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [6:0]            m_digit_char,
    input wire logic                  m_last_digit,
    input wire logic                  m_invalid_input
);

    // invalid word is a lone zero character that closes the response
    a_invalid_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid_input |-> m_last_digit && (m_digit_char == 7'd0))
        else $error("invalid word is not a terminating zero");

    // digit characters stay in 0-9 or A-Z
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invalid_input |->
            ((m_digit_char >= 7'd48) && (m_digit_char <= 7'd57))
         || ((m_digit_char >= 7'd65) && (m_digit_char <= 7'd90)))
        else $error("digit character out of range");

    // no new number is taken while a response is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken during output");

    // a zero number answers with an invalid word in the next cycle
    a_zero_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_number_in == '0) |=> m_valid && m_invalid_input)
        else $error("zero input not flagged");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char) && $stable(m_last_digit))
        else $error("output word changed under stall");

endmodule

bind radix_digit_converter_core rdc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_rdc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_number_in     (s_number_in),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_digit_char    (m_digit_char),
    .m_last_digit    (m_last_digit),
    .m_invalid_input (m_invalid_input)
);

`default_nettype wire

@@ tb/sv/radix_digit_converter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_core_tb
// Feeds numbers through the converter under a series of radix settings,
// including out-of-range register values, and checks each ASCII digit word
// against a digit expansion done in the bench. Both sides idle at random.
// ----------------------------------------------------------------------------

module radix_digit_converter_core_tb;

    import rdc_pkg::*;

    localparam int          VALUE_BITS  = 31;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          PHASES      = 11;
    localparam int          PER_PHASE   = 39;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] number;
        logic                  wait_drain;
    } number_req_t;

    typedef struct packed {
        char_t ch;
        logic  last;
        logic  invalid;
    } digit_word_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [5:0]            cfg_radix   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_number_in = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [6:0]            m_digit_char;
    logic                  m_last_digit;
    logic                  m_invalid_input;

    number_req_t pending_numbers[$];
    digit_word_t expected_digits[$];

    logic [5:0]  radix_setting = RADIX_MIN;
    bit          sender_eager  = 1'b0;
    bit          sink_eager    = 1'b0;
    int          send_gap      = 0;
    int          sink_stall    = 0;
    int          quiet_cycles  = 0;
    int unsigned numbers_sent  = 0;
    int unsigned zeros_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned radix_writes  = 0;
    int unsigned mismatches    = 0;

    radix_digit_converter_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_radix      (cfg_radix),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_number_in    (s_number_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_char   (m_digit_char),
        .m_last_digit   (m_last_digit),
        .m_invalid_input(m_invalid_input)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // expand one number into its digit words, most significant first
    function automatic void convert_number(input logic [VALUE_BITS-1:0] number,
                                           input logic [5:0] radix_raw);
        int unsigned     base;
        longint unsigned rest;
        digit_t          rems[VALUE_BITS];
        int              count;
        digit_word_t     w;
        if (radix_raw < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_raw > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = radix_raw;
        end
        rest  = number;
        count = 0;
        if (rest == 0) begin
            w.ch      = '0;
            w.last    = 1'b1;
            w.invalid = 1'b1;
            expected_digits = {expected_digits, w};
            zeros_sent++;
            return;
        end
        while (rest != 0) begin
            rems[count] = digit_t'(rest % base);
            rest        = rest / base;
            count++;
        end
        for (int k = count - 1; k >= 0; k--) begin
            if (rems[k] < 10) begin
                w.ch = ASCII_ZERO + char_t'(rems[k]);
            end else begin
                w.ch = ASCII_UPPER_A + char_t'(rems[k] - 10);
            end
            w.last    = (k == 0);
            w.invalid = 1'b0;
            expected_digits = {expected_digits, w};
        end
    endfunction

    // random magnitude, biased toward short numbers since long ones divide slowly
    function automatic logic [VALUE_BITS-1:0] draw_number();
        int unsigned           width;
        logic [VALUE_BITS-1:0] v;
        if ($urandom_range(0, 24) == 0) begin
            return '0;
        end
        if ($urandom_range(0, 9) < 7) begin
            width = $urandom_range(1, 12);
        end else begin
            width = $urandom_range(13, VALUE_BITS);
        end
        v = VALUE_BITS'($urandom()) >> (VALUE_BITS - width);
        v[width-1] = 1'b1;
        return v;
    endfunction

    task automatic queue_number(input logic [VALUE_BITS-1:0] number, input bit drain);
        number_req_t req;
        req.number     = number;
        req.wait_drain = drain;
        pending_numbers = {pending_numbers, req};
    endtask

    task automatic wait_until_drained();
        while (pending_numbers.size() != 0 || s_valid || expected_digits.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_radix(input logic [5:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_radix <= value;
        do @(posedge aclk); while (!cfg_ready);
        radix_setting = value;
        cfg_valid <= 1'b0;
        radix_writes++;
        @(negedge aclk);
    endtask

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // sender: one queued number per word, random gap after each acceptance unless eager
    always @(posedge aclk) begin : sender
        number_req_t req;
        bit          present;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            present = s_valid;
            if (s_valid && s_ready) begin
                convert_number(s_number_in, radix_setting);
                numbers_sent++;
                present  = 1'b0;
                send_gap = sender_eager ? 0 : $urandom_range(0, 10);
            end
            if (!present) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_numbers.size() != 0 &&
                             (!pending_numbers[0].wait_drain ||
                              expected_digits.size() == 0)) begin
                    req = pending_numbers.pop_front();
                    s_number_in <= req.number;
                    present = 1'b1;
                end
            end
            s_valid <= present;
        end
    end

    // receiver: checks each digit word, stalls at random after each one unless eager
    always @(posedge aclk) begin : receiver
        digit_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                words_checked++;
                if (expected_digits.size() == 0) begin
                    log_mismatch($sformatf("unexpected word char=%0d last=%0b invalid=%0b",
                                           m_digit_char, m_last_digit, m_invalid_input));
                end else begin
                    want = expected_digits.pop_front();
                    if (m_digit_char !== want.ch || m_last_digit !== want.last ||
                        m_invalid_input !== want.invalid) begin
                        log_mismatch($sformatf(
                            "expected char=%0d last=%0b invalid=%0b, got char=%0d last=%0b invalid=%0b",
                            want.ch, want.last, want.invalid,
                            m_digit_char, m_last_digit, m_invalid_input));
                    end
                end
                sink_stall = sink_eager ? 0 : $urandom_range(0, 10);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // a long division with no handshake is normal; a much longer silence is a hang
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [5:0] fixed_radix[9];
        logic [5:0] radix_pick;
        fixed_radix = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd1, 6'd37, 6'd63, 6'd7};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            wait_until_drained();
            radix_pick = (p < 9) ? fixed_radix[p] : 6'($urandom_range(0, 63));
            write_radix(radix_pick);
            sender_eager = (p == 3) || ($urandom_range(0, 3) == 0);
            sink_eager   = (p == 3) || ($urandom_range(0, 3) == 0);

            case (p)
                0: begin
                    // all-ones gives the longest digit string
                    queue_number('1, 1'b0);
                    queue_number('0, 1'b0);
                    queue_number(1, 1'b0);
                    queue_number(VALUE_BITS'(1) << (VALUE_BITS - 1), 1'b0);
                    queue_number(VALUE_BITS'(32'h5555_5555), 1'b1);
                    queue_number(VALUE_BITS'(32'h2AAA_AAAA), 1'b0);
                end
                1: begin
                    queue_number(35, 1'b0);
                    queue_number(36, 1'b0);
                    queue_number(1295, 1'b0);
                    queue_number(1296, 1'b0);
                    queue_number('1, 1'b0);
                    queue_number('0, 1'b1);
                end
                2: begin
                    queue_number(9, 1'b0);
                    queue_number(10, 1'b0);
                    queue_number('1, 1'b0);
                    queue_number(1000000000, 1'b0);
                end
                4: queue_number(3, 1'b0);
                7: begin
                    queue_number(35, 1'b0);
                    queue_number(36, 1'b0);
                end
                default: ;
            endcase

            for (int i = 0; i < PER_PHASE; i++) begin
                queue_number(draw_number(), $urandom_range(0, 19) == 0);
            end
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("converted %0d numbers (%0d zero) under %0d radix writes, clamped values included",
                 numbers_sent, zeros_sent, radix_writes);
        $display("checked %0d digit words, %0d mismatched", words_checked, mismatches);
        if (mismatches == 0 && expected_digits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
